>>> src/lase_pkg.sv
`default_nettype none
package lase_pkg;

   // Default sizing, handed down from the top level
   localparam int SLOTS_DEF       = 4;
   localparam int ENCODERS_DEF    = 16;
   localparam int PLANES_DEF      = 8;
   localparam int BANK_FRAMES_DEF = 33;

   // Register reset values
   localparam logic [15:0] BANK_DUR_RESET  = 16'd500;
   localparam logic [7:0]  MAX_LEVEL_RESET = 8'd255;

   // Register indexes
   localparam logic [1:0] CSR_BANK_DURATION = 2'd0;
   localparam logic [1:0] CSR_MAX_LEVEL     = 2'd1;

   // Animation kind reserved for bank changes
   localparam logic [2:0] KIND_BANK = 3'd1;

   // Reciprocal of three for 8-bit values: (x * 171) >> 9
   localparam logic [15:0] THIRD_MUL   = 16'd171;
   localparam logic [7:0]  FRAME_SAT   = 8'd255;

   typedef enum logic [1:0] {
      REQ_TICK   = 2'd0,
      REQ_BANK   = 2'd1,
      REQ_CUSTOM = 2'd2,
      REQ_DRAW   = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NO_SLOT   = 2'd1,
      ST_BAD_PARAM = 2'd2,
      ST_NO_ANIM   = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      PH_UP,
      PH_DOWN,
      PH_COLOUR
   } phase_type;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [31:0] now_ms;
      logic [7:0]  bank_sel;
      logic [2:0]  anim_kind;
      logic [7:0]  encoder_index;
      logic [31:0] length_ms;
      logic [7:0]  frame_count;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
   } req_type_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [3:0]  slot_index;
      logic [15:0] redraw_mask;
      logic [4:0]  active_count;
      logic [2:0]  plane_index;
      logic        red_on;
      logic        green_on;
      logic        blue_on;
      logic        last;
   } rsp_type_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CHECK,
      S_CANCEL,
      S_FILL,
      S_REPLY,
      S_TK_TEST,
      S_TK_PER,
      S_TK_Q,
      S_TK_UPD,
      S_FIND,
      S_DR_PREP,
      S_DR_W,
      S_DR_COL,
      S_EMIT
   } state_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_CHECK,
      OP_CANCEL,
      OP_FILL,
      OP_REPLY,
      OP_TK_TEST,
      OP_TK_PER,
      OP_TK_Q,
      OP_TK_UPD,
      OP_FIND,
      OP_DR_PREP,
      OP_DR_W,
      OP_DR_COL,
      OP_EMIT
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      req_kind_type req_kind;
      logic         bad;
      logic         idx_last;
      logic         tk_skip;
      logic         tk_direct;
      logic         div_done;
      logic         quot_zero;
      logic         hit;
      logic         prep_div;
      logic         phase_colour;
      logic         chan_last;
      logic         plane_last;
   } stat_type;

endpackage
`default_nettype wire

>>> src/lase_div.sv
`default_nettype none
module lase_div
   import lase_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [31:0] dividend,
   input  wire logic [31:0] divisor,
   output logic             done,
   output logic [31:0]      quotient
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] quo_ff, quo_in;
   logic [31:0] den_ff, den_in;
   logic [32:0] shifted;
   logic [32:0] diff;

   // One quotient bit a cycle, restoring
   always_comb begin
      shifted = {rem_ff, quo_ff[31]};
      diff    = shifted - {1'b0, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend;
         den_in  = divisor;
      end else if (busy_ff) begin
         if (!diff[32]) begin
            rem_in = diff[31:0];
         end else begin
            rem_in = shifted[31:0];
         end
         quo_in = {quo_ff[30:0], ~diff[32]};
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule
`default_nettype wire

>>> src/lase_ctrl.sv
`default_nettype none
module lase_ctrl
   import lase_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     start,
   output logic          busy,
   input  wire stat_type stat,
   output cmd_type       cmd
);

   state_type state_ff, state_in;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:    if (start) state_in = S_CHECK;
         S_CHECK: begin
            case (stat.req_kind)
               REQ_TICK:   state_in = S_TK_TEST;
               REQ_BANK:   state_in = S_CANCEL;
               REQ_CUSTOM: state_in = stat.bad ? S_REPLY : S_CANCEL;
               REQ_DRAW:   state_in = stat.bad ? S_REPLY : S_FIND;
               default:    state_in = S_REPLY;
            endcase
         end
         S_CANCEL:  if (stat.idx_last) state_in = S_FILL;
         S_FILL:    state_in = S_REPLY;
         S_REPLY:   state_in = S_IDLE;
         S_TK_TEST: begin
            if (stat.tk_skip) begin
               if (stat.idx_last) state_in = S_REPLY;
            end else if (stat.tk_direct) begin
               state_in = S_TK_UPD;
            end else begin
               state_in = S_TK_PER;
            end
         end
         S_TK_PER:  if (stat.div_done) state_in = stat.quot_zero ? S_TK_UPD : S_TK_Q;
         S_TK_Q:    if (stat.div_done) state_in = S_TK_UPD;
         S_TK_UPD:  state_in = stat.idx_last ? S_REPLY : S_TK_TEST;
         S_FIND: begin
            if (stat.hit) state_in = S_DR_PREP;
            else if (stat.idx_last) state_in = S_REPLY;
         end
         S_DR_PREP: state_in = stat.prep_div ? S_DR_W : S_DR_COL;
         S_DR_W:    if (stat.div_done) state_in = stat.phase_colour ? S_DR_COL : S_EMIT;
         S_DR_COL:  state_in = stat.chan_last ? S_EMIT : S_DR_COL;
         S_EMIT:    if (stat.plane_last) state_in = S_IDLE;
         default:   state_in = S_IDLE;
      endcase
   end

   // Commands to the datapath
   always_comb begin
      cmd.op = OP_NONE;
      case (state_ff)
         S_IDLE:    cmd.op = start ? OP_LOAD : OP_NONE;
         S_CHECK:   cmd.op = OP_CHECK;
         S_CANCEL:  cmd.op = OP_CANCEL;
         S_FILL:    cmd.op = OP_FILL;
         S_REPLY:   cmd.op = OP_REPLY;
         S_TK_TEST: cmd.op = OP_TK_TEST;
         S_TK_PER:  cmd.op = OP_TK_PER;
         S_TK_Q:    cmd.op = OP_TK_Q;
         S_TK_UPD:  cmd.op = OP_TK_UPD;
         S_FIND:    cmd.op = OP_FIND;
         S_DR_PREP: cmd.op = OP_DR_PREP;
         S_DR_W:    cmd.op = OP_DR_W;
         S_DR_COL:  cmd.op = OP_DR_COL;
         S_EMIT:    cmd.op = OP_EMIT;
         default:   cmd.op = OP_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule
`default_nettype wire

>>> src/lase_datapath.sv
`default_nettype none
module lase_datapath
   import lase_pkg::*;
#(
   parameter int SLOTS       = SLOTS_DEF,
   parameter int ENCODERS    = ENCODERS_DEF,
   parameter int PLANES      = PLANES_DEF,
   parameter int BANK_FRAMES = BANK_FRAMES_DEF
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire cmd_type      cmd,
   output stat_type         stat,
   input  wire req_type_type req_data,
   output logic             rsp_valid,
   output rsp_type_type     rsp_data,
   input  wire logic         csr_write,
   input  wire logic [1:0]   csr_index,
   input  wire logic [15:0]  csr_wdata
);

   localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   // Configuration registers
   logic [15:0] bank_dur_ff;
   logic [7:0]  max_level_ff;

   // Slot table
   logic        active_ff [SLOTS];
   logic [2:0]  kind_ff   [SLOTS];
   logic [31:0] start_ff  [SLOTS];
   logic [31:0] len_ff    [SLOTS];
   logic [7:0]  frame_ff  [SLOTS];
   logic [7:0]  frames_ff [SLOTS];
   logic [3:0]  enc_ff    [SLOTS];

   // Working registers for one item
   req_type_type req_ff;
   status_type   status_ff;
   logic [IW-1:0] idx_ff;
   logic [IW-1:0] free_ff;
   logic          found_ff;
   logic [3:0]    slot_out_ff;
   logic [15:0]   mask_ff;
   logic          any_ff;
   logic [31:0]   el_ff;
   logic [7:0]    q_ff;
   phase_type     phase_ff;
   logic [7:0]    w_ff;
   logic [7:0]    col_r_ff, col_g_ff, col_b_ff;
   logic [1:0]    chan_ff;
   logic [2:0]    plane_ff;

   // Divider hookup
   logic        div_start;
   logic [31:0] div_num, div_den;
   logic        div_done;
   logic [31:0] div_quot;

   lase_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_num),
      .divisor  (div_den),
      .done     (div_done),
      .quotient (div_quot)
   );

   // Current slot, addressed by the walk counter
   logic        cur_active;
   logic [2:0]  cur_kind;
   logic [31:0] cur_start, cur_len, cur_el;
   logic [7:0]  cur_frame, cur_frames;
   logic [3:0]  cur_enc;
   logic        cur_exp;

   assign cur_active = active_ff[idx_ff];
   assign cur_kind   = kind_ff[idx_ff];
   assign cur_start  = start_ff[idx_ff];
   assign cur_len    = len_ff[idx_ff];
   assign cur_frame  = frame_ff[idx_ff];
   assign cur_frames = frames_ff[idx_ff];
   assign cur_enc    = enc_ff[idx_ff];
   assign cur_el     = req_ff.now_ms - cur_start;
   assign cur_exp    = (cur_el >= cur_len);

   req_kind_type req_kind;
   logic [2:0]   cancel_kind;
   logic         kind_match;
   logic         idx_last;
   logic         enc_bad;
   logic         bad;
   logic [3:0]   bank_enc;
   logic [15:0]  cur_bit;
   logic         hit;

   assign req_kind    = req_kind_type'(req_ff.req_type);
   assign cancel_kind = (req_kind == REQ_BANK) ? KIND_BANK : req_ff.anim_kind;
   assign kind_match  = cur_active && (cur_kind == cancel_kind);
   assign idx_last    = (idx_ff == IW'(SLOTS - 1));
   assign enc_bad     = ({1'b0, req_ff.encoder_index} >= 9'(ENCODERS));
   assign bad         = ((req_kind == REQ_CUSTOM) && (enc_bad || (req_ff.frame_count == 8'd0)))
                     || ((req_kind == REQ_DRAW) && enc_bad);
   assign bank_enc    = (req_ff.bank_sel < 8'd4) ? {2'b00, 2'd3 - req_ff.bank_sel[1:0]} : 4'd3;
   assign cur_bit     = 16'd1 << cur_enc;
   assign hit         = cur_active && (cur_enc == req_ff.encoder_index[3:0])
                     && (cur_kind == KIND_BANK);

   // Draw ramp set-up for the selected slot
   logic [7:0]  tot, fr, seg, span, off;
   logic [8:0]  seg2;
   logic [15:0] third_prod;
   logic [15:0] ramp_prod;
   phase_type   phase;

   always_comb begin
      tot        = cur_frames;
      fr         = (cur_frame > tot) ? tot : cur_frame;
      third_prod = {8'd0, tot} * THIRD_MUL;
      seg        = {1'b0, third_prod[15:9]};
      seg2       = {seg, 1'b0};
      span       = 8'({1'b0, tot} - seg2);
      if (fr < seg) begin
         phase = PH_UP;
         off   = fr;
      end else if ({1'b0, fr} < seg2) begin
         phase = PH_DOWN;
         off   = fr - seg;
      end else begin
         phase = PH_COLOUR;
         off   = 8'({1'b0, fr} - seg2);
      end
      ramp_prod = {8'd0, off} * {8'd0, max_level_ff};
   end

   logic        prep_div;
   logic [7:0]  chan_col;
   logic [15:0] col_prod;
   logic [15:0] col_sum;
   logic [7:0]  col_scaled;

   assign prep_div = (phase != PH_COLOUR) || (span != 8'd0);
   assign chan_col = (chan_ff == 2'd0) ? req_ff.red :
                     (chan_ff == 2'd1) ? req_ff.green : req_ff.blue;
   assign col_prod = {8'd0, chan_col} * {8'd0, w_ff};
   // x / 255 as (x + (x >> 8) + 1) >> 8, exact for x up to 255 * 255
   assign col_sum    = col_prod + {8'd0, col_prod[15:8]} + 16'd1;
   assign col_scaled = col_sum[15:8];

   // Divider requests
   always_comb begin
      div_start = 1'b0;
      div_num   = '0;
      div_den   = '0;
      case (cmd.op)
         OP_TK_TEST: begin
            div_start = cur_active && !cur_exp && (cur_frames != 8'd0);
            div_num   = cur_len;
            div_den   = {24'd0, cur_frames};
         end
         OP_TK_PER: begin
            div_start = div_done && (div_quot != 32'd0);
            div_num   = el_ff;
            div_den   = div_quot;
         end
         OP_DR_PREP: begin
            div_start = prep_div;
            div_num   = {16'd0, ramp_prod};
            div_den   = (phase == PH_COLOUR) ? {24'd0, span} : {24'd0, seg};
         end
         default: begin
            div_start = 1'b0;
         end
      endcase
   end

   // Status to the controller
   always_comb begin
      stat.req_kind     = req_kind;
      stat.bad          = bad;
      stat.idx_last     = idx_last;
      stat.tk_skip      = !cur_active || cur_exp;
      stat.tk_direct    = (cur_frames == 8'd0);
      stat.div_done     = div_done;
      stat.quot_zero    = (div_quot == 32'd0);
      stat.hit          = hit;
      stat.prep_div     = prep_div;
      stat.phase_colour = (phase_ff == PH_COLOUR);
      stat.chan_last    = (chan_ff == 2'd2);
      stat.plane_last   = (plane_ff == 3'(PLANES - 1));
   end

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         bank_dur_ff  <= BANK_DUR_RESET;
         max_level_ff <= MAX_LEVEL_RESET;
      end else if (csr_write) begin
         if (csr_index == CSR_BANK_DURATION) bank_dur_ff <= csr_wdata;
         if (csr_index == CSR_MAX_LEVEL) max_level_ff <= csr_wdata[7:0];
      end
   end

   // Slot valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) active_ff[i] <= 1'b0;
      end else begin
         case (cmd.op)
            OP_CANCEL:  if (kind_match) active_ff[idx_ff] <= 1'b0;
            OP_FILL:    if (found_ff) active_ff[free_ff] <= 1'b1;
            OP_TK_TEST: if (cur_active && cur_exp) active_ff[idx_ff] <= 1'b0;
            default: begin
            end
         endcase
      end
   end

   // Slot payload and per-item working state
   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_LOAD: begin
            req_ff      <= req_data;
            status_ff   <= ST_OK;
            idx_ff      <= '0;
            found_ff    <= 1'b0;
            slot_out_ff <= '0;
            mask_ff     <= '0;
            any_ff      <= 1'b0;
            chan_ff     <= '0;
            plane_ff    <= '0;
         end
         OP_CHECK: begin
            status_ff <= bad ? ST_BAD_PARAM : ST_OK;
         end
         OP_CANCEL: begin
            if (kind_match) mask_ff <= mask_ff | cur_bit;
            if (!found_ff && (!cur_active || kind_match)) begin
               found_ff <= 1'b1;
               free_ff  <= idx_ff;
            end
            idx_ff <= idx_ff + 1'b1;
         end
         OP_FILL: begin
            if (found_ff) begin
               slot_out_ff       <= 4'(free_ff);
               start_ff[free_ff] <= req_ff.now_ms;
               frame_ff[free_ff] <= 8'd0;
               if (req_kind == REQ_BANK) begin
                  kind_ff[free_ff]   <= KIND_BANK;
                  len_ff[free_ff]    <= {16'd0, bank_dur_ff};
                  frames_ff[free_ff] <= 8'(BANK_FRAMES);
                  enc_ff[free_ff]    <= bank_enc;
               end else begin
                  kind_ff[free_ff]   <= req_ff.anim_kind;
                  len_ff[free_ff]    <= req_ff.length_ms;
                  frames_ff[free_ff] <= req_ff.frame_count;
                  enc_ff[free_ff]    <= req_ff.encoder_index[3:0];
               end
            end else begin
               status_ff <= ST_NO_SLOT;
            end
         end
         OP_TK_TEST: begin
            el_ff <= cur_el;
            q_ff  <= FRAME_SAT;
            if (!cur_active || cur_exp) begin
               if (cur_active) begin
                  mask_ff <= mask_ff | cur_bit;
                  any_ff  <= 1'b1;
               end
               idx_ff <= idx_ff + 1'b1;
            end
         end
         OP_TK_Q: begin
            if (div_done) q_ff <= (div_quot[31:8] != 24'd0) ? FRAME_SAT : div_quot[7:0];
         end
         OP_TK_UPD: begin
            if (q_ff != cur_frame) begin
               frame_ff[idx_ff] <= q_ff;
               any_ff           <= 1'b1;
            end
            idx_ff <= idx_ff + 1'b1;
         end
         OP_FIND: begin
            if (!hit) begin
               if (idx_last) status_ff <= ST_NO_ANIM;
               idx_ff <= idx_ff + 1'b1;
            end
         end
         OP_DR_PREP: begin
            phase_ff <= phase;
            w_ff     <= FRAME_SAT;
         end
         OP_DR_W: begin
            if (div_done) begin
               if (phase_ff == PH_COLOUR) begin
                  w_ff <= div_quot[7:0];
               end else if (phase_ff == PH_DOWN) begin
                  col_r_ff <= max_level_ff - div_quot[7:0];
                  col_g_ff <= max_level_ff - div_quot[7:0];
                  col_b_ff <= max_level_ff - div_quot[7:0];
               end else begin
                  col_r_ff <= div_quot[7:0];
                  col_g_ff <= div_quot[7:0];
                  col_b_ff <= div_quot[7:0];
               end
            end
         end
         OP_DR_COL: begin
            case (chan_ff)
               2'd0:    col_r_ff <= col_scaled;
               2'd1:    col_g_ff <= col_scaled;
               default: col_b_ff <= col_scaled;
            endcase
            chan_ff <= chan_ff + 2'd1;
         end
         OP_EMIT: begin
            plane_ff <= plane_ff + 3'd1;
         end
         default: begin
         end
      endcase
   end

   // Table summaries
   logic [4:0]  active_count;
   logic [15:0] active_or;

   always_comb begin
      active_count = '0;
      active_or    = '0;
      for (int i = 0; i < SLOTS; i++) begin
         active_count = active_count + {4'd0, active_ff[i]};
         if (active_ff[i]) active_or = active_or | (16'd1 << enc_ff[i]);
      end
   end

   // Result beat
   always_comb begin
      rsp_valid             = (cmd.op == OP_REPLY) || (cmd.op == OP_EMIT);
      rsp_data.status       = status_ff;
      rsp_data.slot_index   = slot_out_ff;
      rsp_data.redraw_mask  = mask_ff | (any_ff ? active_or : 16'd0);
      rsp_data.active_count = active_count;
      rsp_data.plane_index  = 3'd0;
      rsp_data.red_on       = 1'b0;
      rsp_data.green_on     = 1'b0;
      rsp_data.blue_on      = 1'b0;
      rsp_data.last         = 1'b1;
      if (cmd.op == OP_EMIT) begin
         rsp_data.status      = ST_OK;
         rsp_data.slot_index  = 4'd0;
         rsp_data.redraw_mask = 16'd0;
         rsp_data.plane_index = plane_ff;
         rsp_data.red_on      = col_r_ff[plane_ff];
         rsp_data.green_on    = col_g_ff[plane_ff];
         rsp_data.blue_on     = col_b_ff[plane_ff];
         rsp_data.last        = (plane_ff == 3'(PLANES - 1));
      end
   end

endmodule
`default_nettype wire

>>> src/led_animation_slot_engine.sv
`default_nettype none
// Timed LED animation slot table. A request is taken when start is high and
// busy is low; its results come back as one-cycle beats on rsp_valid and
// cannot be held off, so the receiver must take every beat as it appears.
// Starts and errors give one beat; a tick gives one; a successful draw gives
// one beat per brightness plane, the final beat marked by last. The slots are
// walked one per cycle, but a tick waits on a shared serial divider for each
// slot still running, first for the frame period and, unless that is zero,
// then for the frame. A start walks every slot, cancelling those of its kind,
// and then fills the free one; a draw walks the slots until it finds the bank
// slot of its encoder, divides for the ramp level, scales each colour channel
// in the colour part of the ramp and then gives its beats one per cycle.
// Write registers through csr_ only while busy is low and no beats are due.
module led_animation_slot_engine
   import lase_pkg::*;
#(
   parameter int SLOTS       = SLOTS_DEF,
   parameter int ENCODERS    = ENCODERS_DEF,
   parameter int PLANES      = PLANES_DEF,
   parameter int BANK_FRAMES = BANK_FRAMES_DEF
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   output logic             busy,
   input  wire req_type_type req_data,
   output logic             rsp_valid,
   output rsp_type_type     rsp_data,
   input  wire logic         csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]   csr_index,
   input  wire logic [15:0]  csr_wdata
);

   cmd_type  cmd;
   stat_type stat;

   // Register port never stalls
   assign csr_ready = 1'b1;

   lase_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   lase_datapath #(
      .SLOTS       (SLOTS),
      .ENCODERS    (ENCODERS),
      .PLANES      (PLANES),
      .BANK_FRAMES (BANK_FRAMES)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_write (csr_valid & csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

endmodule
`default_nettype wire

>>> sim/testbench.sv
`default_nettype none
module testbench;
   import lase_pkg::*;

   localparam int NSLOT      = 4;
   localparam int NENC       = 16;
   localparam int NPLANE     = 8;
   localparam int BANK_NFR   = 33;
   localparam int LIMIT      = 600000;
   localparam int PHASE_ITEMS = 50;

   logic         clock;
   logic         reset;
   logic         start;
   logic         busy;
   req_type_type req_data;
   logic         rsp_valid;
   rsp_type_type rsp_data;
   logic         csr_valid;
   logic         csr_ready;
   logic [1:0]   csr_index;
   logic [15:0]  csr_wdata;

   led_animation_slot_engine dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data), .csr_valid(csr_valid),
      .csr_ready(csr_ready), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   // Own copy of the slot table and registers
   logic [15:0] bank_len_ms;
   logic [7:0]  full_level;
   logic        slot_on   [NSLOT];
   logic [2:0]  slot_kd   [NSLOT];
   logic [31:0] slot_t0   [NSLOT];
   logic [31:0] slot_len  [NSLOT];
   logic [7:0]  slot_frm  [NSLOT];
   logic [7:0]  slot_nfr  [NSLOT];
   logic [3:0]  slot_enc  [NSLOT];

   rsp_type_type due_beats[$];
   int errors = 0;
   int cycles = 0;
   int burst_left = 0;
   logic [31:0] clock_ms;

   typedef struct {
      req_type_type req;
      bit           typed;
      rsp_type_type beat;
   } row_type;
   row_type rows[$];

   function automatic logic [4:0] slots_running();
      logic [4:0] n;
      n = 0;
      for (int i = 0; i < NSLOT; i++) if (slot_on[i]) n++;
      return n;
   endfunction

   function automatic rsp_type_type one_beat(status_type st, int slot, logic [15:0] mask,
                                             logic [4:0] act);
      rsp_type_type b;
      b = '0;
      b.status = st; b.slot_index = slot[3:0]; b.redraw_mask = mask;
      b.active_count = act; b.last = 1'b1;
      return b;
   endfunction

   function automatic req_type_type mk_req(req_kind_type k, logic [31:0] now, logic [7:0] bank,
                                           logic [2:0] kind, logic [7:0] enc, logic [31:0] dur,
                                           logic [7:0] nfr, logic [7:0] r, logic [7:0] g,
                                           logic [7:0] b);
      req_type_type q;
      q.req_type = k; q.now_ms = now; q.bank_sel = bank; q.anim_kind = kind;
      q.encoder_index = enc; q.length_ms = dur; q.frame_count = nfr;
      q.red = r; q.green = g; q.blue = b;
      return q;
   endfunction

   // Cancel every running slot of one kind, returning the encoders touched
   function automatic logic [15:0] drop_kind(logic [2:0] kind);
      logic [15:0] m;
      m = '0;
      for (int i = 0; i < NSLOT; i++)
         if (slot_on[i] && slot_kd[i] == kind) begin
            slot_on[i] = 1'b0;
            m[slot_enc[i]] = 1'b1;
         end
      return m;
   endfunction

   // Start a slot in the lowest free entry, or report a full table
   function automatic rsp_type_type claim_slot(logic [2:0] kind, logic [31:0] now,
                                               logic [31:0] len, logic [7:0] nfr,
                                               logic [3:0] enc, logic [15:0] m);
      for (int i = 0; i < NSLOT; i++)
         if (!slot_on[i]) begin
            slot_on[i] = 1'b1; slot_kd[i] = kind; slot_t0[i] = now; slot_len[i] = len;
            slot_frm[i] = 8'd0; slot_nfr[i] = nfr; slot_enc[i] = enc;
            return one_beat(ST_OK, i, m, slots_running());
         end
      return one_beat(ST_NO_SLOT, 0, m, slots_running());
   endfunction

   // Works out the beats of one accepted request and advances the table
   task automatic animate_request(req_type_type q, output rsp_type_type out[$]);
      logic [15:0] m;
      logic [31:0] el, per, quo;
      logic [7:0]  f;
      bit any;
      int s;
      int unsigned tot, fr, seg, ml, span, w, r, g, b;
      rsp_type_type pb;
      out = {};
      case (req_kind_type'(q.req_type))
         REQ_TICK: begin
            m = '0; any = 0;
            for (int i = 0; i < NSLOT; i++) begin
               if (!slot_on[i]) continue;
               el = q.now_ms - slot_t0[i];
               if (el >= slot_len[i]) begin
                  slot_on[i] = 1'b0; any = 1; m[slot_enc[i]] = 1'b1;
                  continue;
               end
               per = (slot_nfr[i] != 0) ? slot_len[i] / slot_nfr[i] : 32'd0;
               quo = (per != 0) ? el / per : 32'd255;
               f = (quo > 255) ? 8'd255 : quo[7:0];
               if (f != slot_frm[i]) begin
                  slot_frm[i] = f; any = 1;
               end
            end
            if (any)
               for (int i = 0; i < NSLOT; i++) if (slot_on[i]) m[slot_enc[i]] = 1'b1;
            out.push_back(one_beat(ST_OK, 0, m, slots_running()));
         end
         REQ_BANK: begin
            m = drop_kind(KIND_BANK);
            out.push_back(claim_slot(KIND_BANK, q.now_ms, {16'd0, bank_len_ms}, BANK_NFR[7:0],
                          (q.bank_sel < 4) ? 4'(3 - q.bank_sel) : 4'd3, m));
         end
         REQ_CUSTOM: begin
            if (q.encoder_index >= NENC || q.frame_count == 0) begin
               out.push_back(one_beat(ST_BAD_PARAM, 0, '0, slots_running()));
            end else begin
               m = drop_kind(q.anim_kind);
               out.push_back(claim_slot(q.anim_kind, q.now_ms, q.length_ms, q.frame_count,
                                        q.encoder_index[3:0], m));
            end
         end
         default: begin
            s = -1;
            if (q.encoder_index < NENC)
               for (int i = 0; i < NSLOT; i++)
                  if (s < 0 && slot_on[i] && slot_enc[i] == q.encoder_index[3:0]
                      && slot_kd[i] == KIND_BANK) s = i;
            if (q.encoder_index >= NENC) begin
               out.push_back(one_beat(ST_BAD_PARAM, 0, '0, slots_running()));
            end else if (s < 0) begin
               out.push_back(one_beat(ST_NO_ANIM, 0, '0, slots_running()));
            end else begin
               tot = slot_nfr[s]; fr = slot_frm[s];
               if (fr > tot) fr = tot;
               seg = tot / 3; ml = full_level;
               // up to white, back down, then up to the requested colour
               if (fr < seg) begin
                  r = (fr * ml / seg) & 255; g = r; b = r;
               end else if (fr < seg * 2) begin
                  w = ((fr - seg) * ml / seg) & 255;
                  r = (ml - w) & 255; g = r; b = r;
               end else begin
                  span = tot - seg * 2;
                  w = (span != 0) ? (((fr - seg * 2) * ml / span) & 255) : 255;
                  r = (q.red * w / 255) & 255;
                  g = (q.green * w / 255) & 255;
                  b = (q.blue * w / 255) & 255;
               end
               for (int p = 0; p < NPLANE; p++) begin
                  pb = '0;
                  pb.status = ST_OK; pb.active_count = slots_running();
                  pb.plane_index = p[2:0];
                  pb.red_on = r[p]; pb.green_on = g[p]; pb.blue_on = b[p];
                  pb.last = (p == NPLANE - 1);
                  out.push_back(pb);
               end
            end
         end
      endcase
   endtask

   // One request beat; the expected beats are queued at the accepting edge
   task automatic issue(req_type_type q, bit typed, rsp_type_type beat);
      rsp_type_type pred[$];
      int gap;
      start <= 1'b1;
      req_data <= q;
      do @(posedge clock); while (busy !== 1'b0);
      animate_request(q, pred);
      if (typed) due_beats.push_back(beat);
      else foreach (pred[i]) due_beats.push_back(pred[i]);
      if (burst_left == 0) begin
         start <= 1'b0;
         gap = $urandom_range(1, 14);
         repeat (gap) @(posedge clock);
         burst_left = $urandom_range(0, 20);
      end else begin
         burst_left--;
      end
   endtask

   task automatic write_reg(logic [1:0] idx, logic [15:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid <= 1'b0;
      if (idx == CSR_BANK_DURATION) bank_len_ms = val;
      else if (idx == CSR_MAX_LEVEL) full_level = val[7:0];
   endtask

   task automatic drain();
      wait (due_beats.size() == 0);
      repeat (20) @(posedge clock);
   endtask

   function automatic req_type_type random_req();
      req_type_type q;
      int pick;
      q = mk_req(REQ_TICK, clock_ms, $urandom, $urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom, $urandom);
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
         q.req_type = REQ_TICK;
         if ($urandom_range(0, 19) == 0) clock_ms = $urandom;
         else clock_ms += $urandom_range(0, 40);
      end else if (pick < 55) begin
         q.req_type = REQ_BANK;
         if ($urandom_range(0, 3) != 0) q.bank_sel = $urandom_range(0, 4);
      end else if (pick < 75) begin
         q.req_type = REQ_CUSTOM;
         if ($urandom_range(0, 2) == 0) q.anim_kind = KIND_BANK;
         if ($urandom_range(0, 9) != 0) q.encoder_index = $urandom_range(0, 15);
         if ($urandom_range(0, 9) != 0) q.length_ms = $urandom_range(0, 300);
         if ($urandom_range(0, 7) != 0) q.frame_count = $urandom_range(1, 40);
      end else begin
         q.req_type = REQ_DRAW;
         if ($urandom_range(0, 9) != 0) q.encoder_index = $urandom_range(0, 5);
      end
      q.now_ms = clock_ms;
      return q;
   endfunction

   // Result checker: each beat against the oldest expectation
   always @(posedge clock) begin
      rsp_type_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (due_beats.size() == 0) begin
            $display("%0t: unexpected beat %p", $time, rsp_data);
            errors++;
         end else begin
            want = due_beats.pop_front();
            if (rsp_data !== want) begin
               $display("%0t: expected st=%0d slot=%0d mask=%h act=%0d pl=%0d rgb=%b%b%b last=%b",
                        $time, want.status, want.slot_index, want.redraw_mask,
                        want.active_count, want.plane_index, want.red_on, want.green_on,
                        want.blue_on, want.last);
               $display("%0t: actual   st=%0d slot=%0d mask=%h act=%0d pl=%0d rgb=%b%b%b last=%b",
                        $time, rsp_data.status, rsp_data.slot_index, rsp_data.redraw_mask,
                        rsp_data.active_count, rsp_data.plane_index, rsp_data.red_on,
                        rsp_data.green_on, rsp_data.blue_on, rsp_data.last);
               errors++;
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT) begin
         $display("led_animation_slot_engine: mismatch");
         $finish;
      end
   end

   task automatic add_row(req_type_type q, bit typed, rsp_type_type beat);
      row_type rw;
      rw.req = q; rw.typed = typed; rw.beat = beat;
      rows.push_back(rw);
   endtask

   initial begin
      logic [15:0] durs[5];
      logic [7:0]  lvls[5];
      rsp_type_type none;
      none = '0;
      durs = '{16'd1, 16'd65535, 16'd100, 16'd40, 16'd500};
      lvls = '{8'd1, 8'd255, 8'd128, 8'd7, 8'd200};
      clock = 1'b0;
      reset <= 1'b1;
      start <= 1'b0;
      req_data <= '0;
      csr_valid <= 1'b0;
      csr_index <= CSR_BANK_DURATION;
      csr_wdata <= '0;
      bank_len_ms = BANK_DUR_RESET;
      full_level = MAX_LEVEL_RESET;
      for (int i = 0; i < NSLOT; i++) begin
         slot_on[i] = 1'b0; slot_kd[i] = '0; slot_t0[i] = '0; slot_len[i] = '0;
         slot_frm[i] = '0; slot_nfr[i] = '0; slot_enc[i] = '0;
      end
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part, starting from the reset table
      add_row(mk_req(REQ_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, one_beat(ST_OK, 0, 0, 0));
      add_row(mk_req(REQ_DRAW, 0, 0, 0, 3, 0, 0, 0, 0, 0), 1, one_beat(ST_NO_ANIM, 0, 0, 0));
      add_row(mk_req(REQ_DRAW, 0, 0, 0, 16, 0, 0, 0, 0, 0), 1,
              one_beat(ST_BAD_PARAM, 0, 0, 0));
      add_row(mk_req(REQ_CUSTOM, 0, 0, 2, 255, 10, 5, 0, 0, 0), 1,
              one_beat(ST_BAD_PARAM, 0, 0, 0));
      add_row(mk_req(REQ_CUSTOM, 0, 0, 2, 4, 10, 0, 0, 0, 0), 1,
              one_beat(ST_BAD_PARAM, 0, 0, 0));
      add_row(mk_req(REQ_BANK, 1000, 0, 0, 0, 0, 0, 0, 0, 0), 1, one_beat(ST_OK, 0, 0, 1));
      // a second bank change cancels the first one's encoder
      add_row(mk_req(REQ_BANK, 1000, 255, 0, 0, 0, 0, 0, 0, 0), 1,
              one_beat(ST_OK, 0, 16'h0008, 1));
      add_row(mk_req(REQ_CUSTOM, 1000, 0, 2, 15, 32'hFFFFFFFF, 255, 0, 0, 0), 1,
              one_beat(ST_OK, 1, 0, 2));
      // custom start of the bank kind, short ramp
      add_row(mk_req(REQ_CUSTOM, 1000, 0, KIND_BANK, 5, 10, 1, 0, 0, 0), 1,
              one_beat(ST_OK, 0, 16'h0008, 2));
      add_row(mk_req(REQ_CUSTOM, 1000, 0, 3, 0, 0, 2, 0, 0, 0), 1, one_beat(ST_OK, 2, 0, 3));
      // zero frame period
      add_row(mk_req(REQ_CUSTOM, 1000, 0, 4, 7, 5, 200, 0, 0, 0), 1,
              one_beat(ST_OK, 3, 0, 4));
      add_row(mk_req(REQ_CUSTOM, 1000, 0, 0, 8, 9, 9, 0, 0, 0), 1,
              one_beat(ST_NO_SLOT, 0, 0, 4));
      add_row(mk_req(REQ_BANK, 1000, 2, 0, 0, 0, 0, 0, 0, 0), 1,
              one_beat(ST_OK, 0, 16'h0020, 4));
      add_row(mk_req(REQ_DRAW, 1000, 0, 0, 1, 0, 0, 8'hFF, 8'h00, 8'hA5), 0, none);
      add_row(mk_req(REQ_TICK, 1003, 0, 0, 0, 0, 0, 0, 0, 0), 0, none);
      add_row(mk_req(REQ_DRAW, 1003, 0, 0, 5, 0, 0, 1, 2, 3), 0, none);
      add_row(mk_req(REQ_CUSTOM, 1003, 0, KIND_BANK, 5, 10, 1, 0, 0, 0), 0, none);
      add_row(mk_req(REQ_TICK, 1200, 0, 0, 0, 0, 0, 0, 0, 0), 0, none);
      add_row(mk_req(REQ_DRAW, 1200, 0, 0, 5, 0, 0, 8'hFF, 8'hFF, 8'hFF), 0, none);
      add_row(mk_req(REQ_DRAW, 1200, 0, 0, 1, 0, 0, 8'h80, 8'h7F, 8'h01), 0, none);
      // non-bank slot is skipped by a draw
      add_row(mk_req(REQ_DRAW, 1200, 0, 0, 15, 0, 0, 8'hFF, 8'hFF, 8'hFF), 0, none);
      add_row(mk_req(REQ_TICK, 32'hFFFFFFFF, 0, 0, 0, 0, 0, 0, 0, 0), 0, none);
      add_row(mk_req(REQ_DRAW, 0, 0, 0, 1, 0, 0, 8'h55, 8'hAA, 8'h0F), 0, none);
      foreach (rows[i]) issue(rows[i].req, rows[i].typed, rows[i].beat);

      // Random phases over several register settings
      for (int ph = 0; ph < 5; ph++) begin
         start <= 1'b0;
         drain();
         write_reg(CSR_BANK_DURATION, durs[ph]);
         write_reg(CSR_MAX_LEVEL, {8'd0, lvls[ph]});
         clock_ms = (ph == 3) ? 32'hFFFFFF80 : $urandom;
         for (int n = 0; n < PHASE_ITEMS; n++) issue(random_req(), 0, none);
      end

      start <= 1'b0;
      wait (due_beats.size() == 0);
      repeat (300) @(posedge clock);
      if (errors == 0) begin
         $display("led_animation_slot_engine: match");
      end else begin
         $display("led_animation_slot_engine: mismatch");
      end
      $finish;
   end

endmodule
`default_nettype wire
